[rtl/tle_pkg.sv]
// Shared types and constants for the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

    localparam int LINE_LENGTH = 64;
    localparam int IDX_W       = $clog2(LINE_LENGTH);
    localparam int CNT_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int LIMIT_RESET = 64;

    localparam logic [BYTE_W-1:0] KEY_ENTER    = 8'd10;
    localparam logic [BYTE_W-1:0] KEY_ESC      = 8'd27;
    localparam logic [BYTE_W-1:0] KEY_TWO      = 8'd50;
    localparam logic [BYTE_W-1:0] KEY_THREE    = 8'd51;
    localparam logic [BYTE_W-1:0] KEY_RIGHT    = 8'd67;
    localparam logic [BYTE_W-1:0] KEY_LEFT     = 8'd68;
    localparam logic [BYTE_W-1:0] KEY_END      = 8'd70;
    localparam logic [BYTE_W-1:0] KEY_HOME     = 8'd72;
    localparam logic [BYTE_W-1:0] KEY_LBRACKET = 8'd91;
    localparam logic [BYTE_W-1:0] KEY_TILDE    = 8'd126;
    localparam logic [BYTE_W-1:0] KEY_BS       = 8'd127;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_BRACKET,
        PH_INS_TILDE,
        PH_DEL_TILDE
    } esc_phase_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_RIGHT,
        OP_LEFT,
        OP_HOME,
        OP_END,
        OP_TOGGLE,
        OP_DELETE,
        OP_BACKSPACE,
        OP_TYPE,
        OP_ENTER
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] ch;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MOVE,
        B_FINISH,
        B_EMIT
    } back_state_t;

endpackage

[rtl/tle_front.sv]
// Front end: accepts key bytes, tracks escape sequences, issues edit commands.
`timescale 1ns / 1ps

module tle_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tle_pkg::BYTE_W-1:0] key_byte,
    input  logic                       q_full,
    output logic                       busy,
    output logic                       push,
    output tle_pkg::cmd_t              push_cmd
);
    import tle_pkg::*;

    esc_phase_t phase_reg;
    esc_phase_t phase_next;
    op_t        op;

    assign busy = q_full;
    assign push = start && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        op         = OP_NOP;
        case (phase_reg)
            PH_ESC:
            begin
                phase_next = (key_byte == KEY_LBRACKET) ? PH_BRACKET : PH_IDLE;
            end
            PH_BRACKET:
            begin
                phase_next = PH_IDLE;
                if (key_byte == KEY_TWO)
                    phase_next = PH_INS_TILDE;
                else if (key_byte == KEY_THREE)
                    phase_next = PH_DEL_TILDE;
                else if (key_byte == KEY_RIGHT)
                    op = OP_RIGHT;
                else if (key_byte == KEY_LEFT)
                    op = OP_LEFT;
                else if (key_byte == KEY_HOME)
                    op = OP_HOME;
                else if (key_byte == KEY_END)
                    op = OP_END;
            end
            PH_INS_TILDE:
            begin
                phase_next = PH_IDLE;
                if (key_byte == KEY_TILDE)
                    op = OP_TOGGLE;
            end
            PH_DEL_TILDE:
            begin
                phase_next = PH_IDLE;
                if (key_byte == KEY_TILDE)
                    op = OP_DELETE;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (key_byte == KEY_ESC)
                    phase_next = PH_ESC;
                else if (key_byte == KEY_ENTER)
                    op = OP_ENTER;
                else if (key_byte == KEY_BS)
                    op = OP_BACKSPACE;
                else
                    op = OP_TYPE;
            end
        endcase
        // hold the phase unless a word is taken
        if (!push)
            phase_next = phase_reg;
    end

    assign push_cmd.op = op;
    assign push_cmd.ch = key_byte;

endmodule

[rtl/tle_cmd_fifo.sv]
// Short command queue between the decoder and the line engine.
`timescale 1ns / 1ps

module tle_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tle_pkg::cmd_t push_cmd,
    input  logic          pop,
    output tle_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          not_empty
);
    import tle_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/tle_back.sv]
// Line engine: runs edit commands on the line store and drives result words.
`timescale 1ns / 1ps

module tle_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tle_pkg::cmd_t              cmd,
    input  logic                       cmd_valid,
    output logic                       cmd_pop,
    input  logic [tle_pkg::CNT_W-1:0]  line_limit,
    output logic                       strobe,
    output logic                       result_kind,
    output logic [tle_pkg::CNT_W-1:0]  line_length,
    output logic [tle_pkg::CNT_W-1:0]  cursor_place,
    output logic                       insert_on,
    output logic [tle_pkg::BYTE_W-1:0] line_char,
    output logic                       char_valid,
    output logic                       last
);
    import tle_pkg::*;

    logic [BYTE_W-1:0] mem [LINE_LENGTH];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic              ins_reg, ins_next;
    op_t               op_reg, op_next;
    logic [BYTE_W-1:0] ch_reg, ch_next;
    logic [IDX_W-1:0]  src_reg, src_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              up_reg, up_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;

    logic              strobe_reg, strobe_next;
    logic              kind_reg, kind_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  curp_reg, curp_next;
    logic              ins_out_reg, ins_out_next;
    logic [BYTE_W-1:0] char_reg, char_next;
    logic              cvalid_reg, cvalid_next;
    logic              last_reg, last_next;

    logic              status_emit;
    logic [CNT_W-1:0]  eff_lim;
    logic              emit_last;

    always_comb
    begin
        if (line_limit == '0)
            eff_lim = CNT_W'(1);
        else if (line_limit > CNT_W'(LINE_LENGTH))
            eff_lim = CNT_W'(LINE_LENGTH);
        else
            eff_lim = line_limit;
    end

    assign emit_last = (pend_addr_reg == IDX_W'(fill_reg - 1'b1));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cur_next       = cur_reg;
        ins_next       = ins_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        src_next       = src_reg;
        left_next      = left_reg;
        up_next        = up_reg;
        pend_vld_next  = 1'b0;
        pend_addr_next = pend_addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        cmd_pop        = 1'b0;
        status_emit    = 1'b0;
        strobe_next    = 1'b0;
        kind_next      = kind_reg;
        len_next       = len_reg;
        curp_next      = curp_reg;
        ins_out_next   = ins_out_reg;
        char_next      = char_reg;
        cvalid_next    = cvalid_reg;
        last_next      = last_reg;

        case (state_reg)
            B_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid)
                begin
                    op_next = cmd.op;
                    ch_next = cmd.ch;
                    case (cmd.op)
                        OP_RIGHT:
                        begin
                            if (cur_reg < fill_reg)
                                cur_next = cur_reg + 1'b1;
                            status_emit = 1'b1;
                        end
                        OP_LEFT:
                        begin
                            if (cur_reg != '0)
                                cur_next = cur_reg - 1'b1;
                            status_emit = 1'b1;
                        end
                        OP_HOME:
                        begin
                            cur_next    = '0;
                            status_emit = 1'b1;
                        end
                        OP_END:
                        begin
                            cur_next    = fill_reg;
                            status_emit = 1'b1;
                        end
                        OP_TOGGLE:
                        begin
                            ins_next    = !ins_reg;
                            status_emit = 1'b1;
                        end
                        OP_DELETE:
                        begin
                            if (cur_reg < fill_reg)
                            begin
                                // close the gap at the cursor, left shift
                                src_next   = IDX_W'(cur_reg + 1'b1);
                                up_next    = 1'b1;
                                left_next  = fill_reg - cur_reg - 1'b1;
                                state_next = B_MOVE;
                            end
                            else
                            begin
                                status_emit = 1'b1;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (cur_reg != '0)
                            begin
                                src_next   = IDX_W'(cur_reg);
                                up_next    = 1'b1;
                                left_next  = fill_reg - cur_reg;
                                state_next = B_MOVE;
                            end
                            else
                            begin
                                status_emit = 1'b1;
                            end
                        end
                        OP_TYPE:
                        begin
                            if (fill_reg >= eff_lim)
                            begin
                                status_emit = 1'b1;
                            end
                            else if (ins_reg)
                            begin
                                // open a gap at the cursor, right shift from the end
                                src_next   = IDX_W'(fill_reg - 1'b1);
                                up_next    = 1'b0;
                                left_next  = fill_reg - cur_reg;
                                state_next = B_MOVE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = IDX_W'(cur_reg);
                                mem_wdata = cmd.ch;
                                if (cur_reg == fill_reg)
                                    fill_next = fill_reg + 1'b1;
                                cur_next    = cur_reg + 1'b1;
                                status_emit = 1'b1;
                            end
                        end
                        OP_ENTER:
                        begin
                            if (fill_reg == '0)
                            begin
                                ins_next     = 1'b0;
                                strobe_next  = 1'b1;
                                kind_next    = 1'b1;
                                len_next     = '0;
                                curp_next    = '0;
                                ins_out_next = 1'b0;
                                char_next    = '0;
                                cvalid_next  = 1'b0;
                                last_next    = 1'b1;
                            end
                            else
                            begin
                                src_next   = '0;
                                left_next  = fill_reg;
                                state_next = B_EMIT;
                            end
                        end
                        default:
                        begin
                            status_emit = 1'b1;
                        end
                    endcase
                end
            end
            B_MOVE:
            begin
                if (pend_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = rd_data_reg;
                end
                if (left_reg != '0)
                begin
                    pend_vld_next  = 1'b1;
                    pend_addr_next = up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    src_next       = up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    left_next      = left_reg - 1'b1;
                end
                else
                begin
                    state_next = B_FINISH;
                end
            end
            B_FINISH:
            begin
                case (op_reg)
                    OP_TYPE:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(cur_reg);
                        mem_wdata = ch_reg;
                        fill_next = fill_reg + 1'b1;
                        cur_next  = cur_reg + 1'b1;
                    end
                    OP_DELETE:
                    begin
                        fill_next = fill_reg - 1'b1;
                    end
                    OP_BACKSPACE:
                    begin
                        fill_next = fill_reg - 1'b1;
                        cur_next  = cur_reg - 1'b1;
                    end
                    default:
                    begin
                        fill_next = fill_reg;
                    end
                endcase
                status_emit = 1'b1;
                state_next  = B_IDLE;
            end
            B_EMIT:
            begin
                if (left_reg != '0)
                begin
                    pend_vld_next  = 1'b1;
                    pend_addr_next = src_reg;
                    src_next       = src_reg + 1'b1;
                    left_next      = left_reg - 1'b1;
                end
                if (pend_vld_reg)
                begin
                    strobe_next  = 1'b1;
                    kind_next    = 1'b1;
                    len_next     = fill_reg;
                    curp_next    = CNT_W'(pend_addr_reg);
                    ins_out_next = 1'b0;
                    char_next    = rd_data_reg;
                    cvalid_next  = 1'b1;
                    last_next    = emit_last;
                    if (emit_last)
                    begin
                        fill_next     = '0;
                        cur_next      = '0;
                        ins_next      = 1'b0;
                        pend_vld_next = 1'b0;
                        state_next    = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (status_emit)
        begin
            strobe_next  = 1'b1;
            kind_next    = 1'b0;
            len_next     = fill_next;
            curp_next    = cur_next;
            ins_out_next = ins_next;
            char_next    = '0;
            cvalid_next  = 1'b0;
            last_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            fill_reg     <= '0;
            cur_reg      <= '0;
            ins_reg      <= 1'b0;
            left_reg     <= '0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            cur_reg      <= cur_next;
            ins_reg      <= ins_next;
            left_reg     <= left_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ch_reg        <= ch_next;
        src_reg       <= src_next;
        up_reg        <= up_next;
        pend_addr_reg <= pend_addr_next;
        kind_reg      <= kind_next;
        len_reg       <= len_next;
        curp_reg      <= curp_next;
        ins_out_reg   <= ins_out_next;
        char_reg      <= char_next;
        cvalid_reg    <= cvalid_next;
        last_reg      <= last_next;
    end

    // line store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[src_reg];
    end

    assign strobe       = strobe_reg;
    assign result_kind  = kind_reg;
    assign line_length  = len_reg;
    assign cursor_place = curp_reg;
    assign insert_on    = ins_out_reg;
    assign line_char    = char_reg;
    assign char_valid   = cvalid_reg;
    assign last         = last_reg;

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= fill_reg)
        else $error("cursor beyond end of line");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(LINE_LENGTH))
        else $error("line fill exceeds store depth");

    a_emit_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |=> strobe_reg && kind_reg)
        else $error("gap inside a finished line burst");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !kind_reg |-> last_reg && !cvalid_reg)
        else $error("status word not marked last");

endmodule

[rtl/terminal_line_editor.sv]
// A key word passes the command queue before the line engine registers its status word.
// A shifting edit first moves the line tail; Enter gives n characters, one per cycle.
// The line engine takes one word at a time; the one-read one-write line store
// sweep (one character moved per cycle) sets the rate at which words are taken.
// Reset clears control state, line and mode; store contents stay undefined; limit 64.
// The result receiver cannot stall: each result word is shown for one cycle.
`timescale 1ns / 1ps

module terminal_line_editor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tle_pkg::BYTE_W-1:0] key_byte,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tle_pkg::CNT_W-1:0]  cfg_data,
    output logic                       strobe,
    output logic                       result_kind,
    output logic [tle_pkg::CNT_W-1:0]  line_length,
    output logic [tle_pkg::CNT_W-1:0]  cursor_place,
    output logic                       insert_on,
    output logic [tle_pkg::BYTE_W-1:0] line_char,
    output logic                       char_valid,
    output logic                       last
);
    import tle_pkg::*;

    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] limit_next;
    logic             q_full;
    logic             q_not_empty;
    logic             push;
    logic             pop;
    cmd_t             push_cmd;
    cmd_t             pop_cmd;

    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CNT_W'(LIMIT_RESET);
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    tle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .key_byte (key_byte),
        .q_full   (q_full),
        .busy     (busy),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tle_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    tle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pop_cmd),
        .cmd_valid    (q_not_empty),
        .cmd_pop      (pop),
        .line_limit   (limit_reg),
        .strobe       (strobe),
        .result_kind  (result_kind),
        .line_length  (line_length),
        .cursor_place (cursor_place),
        .insert_on    (insert_on),
        .line_char    (line_char),
        .char_valid   (char_valid),
        .last         (last)
    );

endmodule

[tb/sv/terminal_line_editor_tb.sv]
// Self-checking testbench for the terminal line editor: key stream in, status and line words out.
`timescale 1ns / 1ps

module terminal_line_editor_tb;

    import tle_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic              kind;
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  pos;
        logic              ins;
        logic [BYTE_W-1:0] ch;
        logic              ch_ok;
        logic              is_last;
    } editor_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [BYTE_W-1:0] key_byte = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              strobe;
    logic              result_kind;
    logic [CNT_W-1:0]  line_length;
    logic [CNT_W-1:0]  cursor_place;
    logic              insert_on;
    logic [BYTE_W-1:0] line_char;
    logic              char_valid;
    logic              last;

    logic [BYTE_W-1:0] key_q[$];
    editor_word_t      pending_words[$];
    int                err_count = 0;
    int                cycles = 0;
    int                burst_left = 0;
    int                gap_left = 0;

    // shadow of the editor state
    esc_phase_t        seq_phase;
    logic [BYTE_W-1:0] line_mem [LINE_LENGTH];
    int                fill;
    int                cur;
    logic              ins_mode;
    int                limit_raw;

    terminal_line_editor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .key_byte     (key_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .result_kind  (result_kind),
        .line_length  (line_length),
        .cursor_place (cursor_place),
        .insert_on    (insert_on),
        .line_char    (line_char),
        .char_valid   (char_valid),
        .last         (last)
    );

    always #1 clk = ~clk;

    task automatic report_error(input string msg);
        err_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic drop_char(input int at);
        if (at >= fill) return;
        for (int i = at; i + 1 < fill; i++) line_mem[i] = line_mem[i + 1];
        fill--;
    endtask

    // Work out the words one accepted key causes and queue them.
    task automatic edit_line(input logic [BYTE_W-1:0] b);
        int lim;
        lim = (limit_raw < 1) ? 1 : (limit_raw > LINE_LENGTH) ? LINE_LENGTH : limit_raw;
        case (seq_phase)
            PH_ESC: seq_phase = (b == KEY_LBRACKET) ? PH_BRACKET : PH_IDLE;
            PH_BRACKET: begin
                seq_phase = PH_IDLE;
                if (b == KEY_TWO) seq_phase = PH_INS_TILDE;
                else if (b == KEY_THREE) seq_phase = PH_DEL_TILDE;
                else if (b == KEY_RIGHT) begin
                    if (cur < fill) cur++;
                end
                else if (b == KEY_LEFT) begin
                    if (cur > 0) cur--;
                end
                else if (b == KEY_HOME) cur = 0;
                else if (b == KEY_END) cur = fill;
            end
            PH_INS_TILDE: begin
                seq_phase = PH_IDLE;
                if (b == KEY_TILDE) ins_mode = ~ins_mode;
            end
            PH_DEL_TILDE: begin
                seq_phase = PH_IDLE;
                if (b == KEY_TILDE) drop_char(cur);
            end
            default: begin
                seq_phase = PH_IDLE;
                if (b == KEY_ESC) seq_phase = PH_ESC;
                else if (b == KEY_ENTER) begin
                    if (fill == 0)
                        pending_words.push_back('{1'b1, '0, '0, 1'b0, '0, 1'b0, 1'b1});
                    else
                        for (int i = 0; i < fill; i++)
                            pending_words.push_back('{1'b1, CNT_W'(fill), CNT_W'(i), 1'b0,
                                                      line_mem[i], 1'b1, i == fill - 1});
                    fill     = 0;
                    cur      = 0;
                    ins_mode = 1'b0;
                    return;
                end
                else if (b == KEY_BS) begin
                    if (cur > 0) begin
                        drop_char(cur - 1);
                        cur--;
                    end
                end
                else if (fill < lim) begin
                    if (ins_mode) begin
                        for (int i = fill; i > cur; i--) line_mem[i] = line_mem[i - 1];
                        fill++;
                    end
                    else if (cur == fill) fill++;
                    line_mem[cur] = b;
                    cur++;
                end
            end
        endcase
        if (cur > fill) cur = fill;
        pending_words.push_back('{1'b0, CNT_W'(fill), CNT_W'(cur), ins_mode, '0, 1'b0, 1'b1});
    endtask

    always @(posedge clk) begin : key_driver
        logic              go;
        logic [BYTE_W-1:0] nxt;
        go  = start;
        nxt = key_byte;
        if (!rst_n) go = 1'b0;
        else begin
            if (start && !busy) begin
                edit_line(key_byte);
                go = 1'b0;
            end
            if (!go) begin
                if (gap_left > 0) gap_left--;
                else if (key_q.size() > 0) begin
                    go  = 1'b1;
                    nxt = key_q.pop_front();
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        start    <= go;
        key_byte <= nxt;
    end

    always @(posedge clk) begin : result_monitor
        editor_word_t seen;
        editor_word_t want;
        if (rst_n && strobe) begin
            seen = '{result_kind, line_length, cursor_place, insert_on,
                     line_char, char_valid, last};
            if (pending_words.size() == 0)
                report_error($sformatf("unexpected word %p", seen));
            else begin
                want = pending_words.pop_front();
                if (seen !== want)
                    report_error($sformatf("word mismatch: got %p, want %p", seen, want));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [BYTE_W-1:0] rand_text();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        while (b == KEY_ENTER || b == KEY_ESC || b == KEY_BS) b = BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic push_text(input int count);
        repeat (count) key_q.push_back(rand_text());
    endtask

    task automatic push_seq(input logic [BYTE_W-1:0] code);
        key_q.push_back(KEY_ESC);
        key_q.push_back(KEY_LBRACKET);
        key_q.push_back(code);
    endtask

    task automatic push_tilde(input logic [BYTE_W-1:0] code);
        push_seq(code);
        key_q.push_back(KEY_TILDE);
    endtask

    // Mostly well-formed editing with random content, plus broken sequences and noise.
    task automatic push_session(input int count);
        int                pick;
        logic [BYTE_W-1:0] nav [4];
        nav = '{KEY_RIGHT, KEY_LEFT, KEY_HOME, KEY_END};
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) push_text($urandom_range(1, 8));
            else if (pick < 60) push_seq(nav[$urandom_range(0, 3)]);
            else if (pick < 68) push_tilde(KEY_TWO);
            else if (pick < 76) push_tilde(KEY_THREE);
            else if (pick < 84) key_q.push_back(KEY_BS);
            else if (pick < 89) key_q.push_back(KEY_ENTER);
            else if (pick < 95) begin
                key_q.push_back(KEY_ESC);
                if ($urandom_range(0, 1)) key_q.push_back(KEY_LBRACKET);
                if ($urandom_range(0, 1)) key_q.push_back($urandom_range(0, 1) ? KEY_TWO : KEY_THREE);
                key_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            else key_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (key_q.size() != 0 || start || pending_words.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        drain();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_raw = v;
    endtask

    initial begin
        seq_phase = PH_IDLE;
        fill      = 0;
        cur       = 0;
        ins_mode  = 1'b0;
        limit_raw = LIMIT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // edge bytes, every command, cursor at both ends, broken sequences
        key_q.push_back(KEY_ENTER);
        key_q.push_back(8'd97);
        key_q.push_back(8'd49);
        key_q.push_back(8'h00);
        key_q.push_back(8'hFF);
        push_seq(KEY_LEFT);
        push_seq(KEY_HOME);
        push_seq(KEY_LEFT);
        key_q.push_back(KEY_BS);
        push_seq(KEY_RIGHT);
        push_tilde(KEY_TWO);
        key_q.push_back(8'd120);
        push_seq(KEY_END);
        push_seq(KEY_RIGHT);
        push_tilde(KEY_THREE);
        push_seq(KEY_HOME);
        push_tilde(KEY_THREE);
        key_q.push_back(KEY_BS);
        push_seq(KEY_END);
        key_q.push_back(KEY_BS);
        key_q.push_back(KEY_ESC);
        key_q.push_back(KEY_ESC);
        push_seq(KEY_ENTER);
        push_seq(8'd90);
        push_seq(KEY_TWO);
        key_q.push_back(KEY_BS);
        key_q.push_back(KEY_ENTER);

        // zero saturates to one character
        write_limit(7'd0);
        push_text(3);
        key_q.push_back(KEY_ENTER);

        // top value saturates to the full store; fill it in both modes
        write_limit(7'd127);
        push_text(40);
        push_tilde(KEY_TWO);
        push_seq(KEY_HOME);
        push_text(30);
        push_tilde(KEY_TWO);
        push_seq(KEY_LEFT);
        push_text(3);
        key_q.push_back(KEY_ENTER);

        // keep a line across a lowered limit
        write_limit(7'd5);
        push_text(10);
        write_limit(7'd2);
        push_text(3);
        key_q.push_back(KEY_BS);
        push_text(2);
        key_q.push_back(KEY_ENTER);

        write_limit(7'($urandom_range(1, 127)));
        push_session(8);
        write_limit(7'd64);
        push_session(8);
        write_limit(7'($urandom_range(0, 20)));
        push_session(8);
        write_limit(7'($urandom_range(30, 80)));
        push_session(8);
        write_limit(7'd1);
        push_session(4);
        write_limit(7'd64);
        push_session(6);
        key_q.push_back(KEY_ENTER);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/tle_pkg.sv
rtl/tle_front.sv
rtl/tle_cmd_fifo.sv
rtl/tle_back.sv
rtl/terminal_line_editor.sv
tb/sv/terminal_line_editor_tb.sv
